[hw/rtl/bzp_pkg.sv]
// ----------------------------------------------------------------------------
// Biquadratic Bezier patch evaluator package
// Shared widths, types and the reciprocal table used to turn a grid step
// into the Q1.16 patch parameter.
// ----------------------------------------------------------------------------
`default_nettype none

package bzp_pkg;

   // Field widths of the stream transactions.
   localparam int CTRL_W      = 32;
   localparam int STEP_W      = 5;
   localparam int LVL_W       = 5;
   localparam int NUM_CTRL    = 9;
   localparam int REQ_TDATA_W = 304;
   localparam int RSP_TDATA_W = 32;

   // Reset value of the level register.
   localparam logic [LVL_W-1:0] LEVEL_RESET = 5'd8;

   // Patch parameter t is unsigned Q1.16, 0 to 1.0 inclusive.
   localparam int T_W = 17;
   localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

   // Step division: t = (n * RECIP) >> RECIP_SH with n below 2^21.
   localparam int NUM_W    = 21;
   localparam int RECIP_W  = 27;
   localparam int RECIP_SH = 26;
   localparam int TPROD_W  = NUM_W + RECIP_W;

   // Bernstein weights are exact Q.32 values up to 2^32.
   localparam int WGT_W = 33;

   // Width of the fully exact accumulated sum, scale 2^64.
   localparam int ACC_W = 97;

   typedef logic [WGT_W-1:0] wgt_type;

   // Stage enables handed to each weight unit.
   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } bzp_wt_en_type;

   // Rounded-up reciprocal ceil(2^26 / L). With L up to 31 and a
   // numerator below 2^21, the truncated product equals the exact floor.
   function automatic logic [RECIP_W-1:0] bzp_recip(input logic [LVL_W-1:0] lvl);
      logic [RECIP_W-1:0] r;
      unique case (lvl)
         5'd0:  r = 27'd0;
         5'd1:  r = 27'd67108864;
         5'd2:  r = 27'd33554432;
         5'd3:  r = 27'd22369622;
         5'd4:  r = 27'd16777216;
         5'd5:  r = 27'd13421773;
         5'd6:  r = 27'd11184811;
         5'd7:  r = 27'd9586981;
         5'd8:  r = 27'd8388608;
         5'd9:  r = 27'd7456541;
         5'd10: r = 27'd6710887;
         5'd11: r = 27'd6100806;
         5'd12: r = 27'd5592406;
         5'd13: r = 27'd5162221;
         5'd14: r = 27'd4793491;
         5'd15: r = 27'd4473925;
         5'd16: r = 27'd4194304;
         5'd17: r = 27'd3947581;
         5'd18: r = 27'd3728271;
         5'd19: r = 27'd3532046;
         5'd20: r = 27'd3355444;
         5'd21: r = 27'd3195661;
         5'd22: r = 27'd3050403;
         5'd23: r = 27'd2917777;
         5'd24: r = 27'd2796203;
         5'd25: r = 27'd2684355;
         5'd26: r = 27'd2581111;
         5'd27: r = 27'd2485514;
         5'd28: r = 27'd2396746;
         5'd29: r = 27'd2314099;
         5'd30: r = 27'd2236963;
         5'd31: r = 27'd2164803;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bzp_weight.sv]
// ----------------------------------------------------------------------------
// Bezier weight unit
// Two pipeline stages: grid step to Q1.16 parameter t, then the three
// quadratic Bernstein weights (1-t)^2, 2t(1-t) and t^2 as exact Q.32 values.
// ----------------------------------------------------------------------------
`default_nettype none

module bzp_weight (
   input  wire logic                          clock,
   input  wire logic [bzp_pkg::STEP_W-1:0]    step,
   input  wire logic [bzp_pkg::LVL_W-1:0]     lvl_eff,
   input  wire logic [bzp_pkg::RECIP_W-1:0]   recip,
   input  wire bzp_pkg::bzp_wt_en_type        stage_en,
   output bzp_pkg::wgt_type                   wgt [3]
);
   import bzp_pkg::*;

   logic [STEP_W-1:0]  step_clamp;
   logic [NUM_W-1:0]   num;
   logic [TPROD_W-1:0] tprod;
   logic [T_W-1:0]     t_in;
   logic [T_W-1:0]     t_ff;
   logic [T_W-1:0]     s_val;
   logic [2*T_W-1:0]   ss_prod;
   logic [2*T_W-1:0]   st_prod;
   logic [2*T_W-1:0]   tt_prod;
   wgt_type            wgt_in [3];
   wgt_type            wgt_ff [3];

   // Clamp the step to the level and divide with rounding by the reciprocal.
   always_comb begin
      step_clamp = (step > lvl_eff) ? lvl_eff : step;
      num        = {step_clamp, 16'd0} + NUM_W'(lvl_eff[LVL_W-1:1]);
      tprod      = TPROD_W'(num) * TPROD_W'(recip);
      t_in       = tprod[RECIP_SH +: T_W];
   end

   // Stage one register: parameter t.
   always_ff @(posedge clock) begin
      if (stage_en.s1_en) begin
         t_ff <= t_in;
      end
   end

   // Bernstein weights; each fits in 33 bits since s + t is one.
   always_comb begin
      s_val     = ONE_Q16 - t_ff;
      ss_prod   = (2*T_W)'(s_val) * (2*T_W)'(s_val);
      st_prod   = (2*T_W)'(s_val) * (2*T_W)'(t_ff);
      tt_prod   = (2*T_W)'(t_ff) * (2*T_W)'(t_ff);
      wgt_in[0] = ss_prod[WGT_W-1:0];
      wgt_in[1] = {st_prod[WGT_W-2:0], 1'b0};
      wgt_in[2] = tt_prod[WGT_W-1:0];
   end

   // Stage two register: weights.
   always_ff @(posedge clock) begin
      if (stage_en.s2_en) begin
         for (int i = 0; i < 3; i++) begin
            wgt_ff[i] <= wgt_in[i];
         end
      end
   end

   assign wgt = wgt_ff;

endmodule

`default_nettype wire

[hw/rtl/bezier_patch_point_eval_core.sv]
// ----------------------------------------------------------------------------
// Biquadratic Bezier patch point evaluator
// Evaluates one scalar component of a 3x3 quadratic Bezier patch at a grid
// point of a level-by-level tessellation, rounded and saturated to Q16.16.
//
//   Channel   Direction  Contents
//   req_*     in         nine Q16.16 control values, row step, column step
//   rsp_*     out        point value (tdata), saturation flag (tuser)
//   csr_*     in         tessellation level, write only
//
// One transaction per cycle is accepted while the pipeline is not full behind a
// stalled output. A result passes through the eight register stages of the
// multiply and accumulate pipeline before it shows on the output. Reset clears
// all stage valid bits and sets the level to 8. Each stage holds while the
// stage after it is full and stalled, so bubbles are squeezed out and nothing
// is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_patch_point_eval_core #(
   parameter int MAX_LEVEL = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Fields from bit 0: ctrl_r0c0 .. ctrl_r2c2 (32 each), row_step (5),
   // col_step (5), zero fill (6).
   input  wire logic [bzp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: point_value (32).
   output logic [bzp_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // Fields from bit 0: saturated (1).
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_wr_en,
   input  wire logic [bzp_pkg::LVL_W-1:0]         csr_wr_data
);
   import bzp_pkg::*;

   localparam int NST = 8;
   localparam logic signed [ACC_W-1:0] RND_HALF = {33'd0, 1'b1, 63'd0};

   // Control and pipeline bookkeeping.
   logic [LVL_W-1:0]    csr_level_ff;
   logic [LVL_W-1:0]    lvl_eff;
   logic [RECIP_W-1:0]  recip;
   logic [NST:1]        vld_ff;
   logic [NST:1]        adv;
   bzp_wt_en_type       wt_en;

   // Input unpacking.
   logic [CTRL_W-1:0]   ctrl_in [3][3];
   logic [STEP_W-1:0]   row_step;
   logic [STEP_W-1:0]   col_step;

   // Pipeline payload.
   logic [CTRL_W-1:0]          ctrl_s1_ff [3][3];
   logic [CTRL_W-1:0]          ctrl_s2_ff [3][3];
   wgt_type                    wr [3];
   wgt_type                    wc [3];
   wgt_type                    wc_s3_ff [3];
   wgt_type                    wc_s4_ff [3];
   logic signed [65:0]         prod_full [3][3];
   logic signed [63:0]         prod_s3_ff [3][3];
   logic signed [63:0]         col_in [3];
   logic signed [63:0]         col_s4_ff [3];
   logic signed [65:0]         pph_full [3];
   logic [64:0]                ppl_full [3];
   logic signed [63:0]         pph_s5_ff [3];
   logic [63:0]                ppl_s5_ff [3];
   logic signed [ACC_W-1:0]    term_in [3];
   logic signed [ACC_W-1:0]    term_s6_ff [3];
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [ACC_W-1:0]    acc_s7_ff;
   logic [32:0]                rnd_val;
   logic [RSP_TDATA_W-1:0]     point_in;
   logic                       sat_in;
   logic [RSP_TDATA_W-1:0]     point_s8_ff;
   logic                       sat_s8_ff;

   // Level register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_level_ff <= LEVEL_RESET;
      end else if (csr_wr_en) begin
         csr_level_ff <= csr_wr_data;
      end
   end

   // Effective level: zero reads as one, and the level is capped.
   always_comb begin
      priority if (csr_level_ff == '0) begin
         lvl_eff = LVL_W'(1);
      end else if (int'(csr_level_ff) > MAX_LEVEL) begin
         lvl_eff = LVL_W'(MAX_LEVEL);
      end else begin
         lvl_eff = csr_level_ff;
      end
      recip = bzp_recip(lvl_eff);
   end

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      adv[NST] = !vld_ff[NST] || rsp_tready;
      for (int k = NST - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[1];
   assign wt_en      = {adv[1], adv[2]};

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) begin
            vld_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Unpack the request transaction.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ctrl_in[r][c] = req_tdata[(r*3 + c)*CTRL_W +: CTRL_W];
         end
      end
      row_step = req_tdata[NUM_CTRL*CTRL_W +: STEP_W];
      col_step = req_tdata[NUM_CTRL*CTRL_W + STEP_W +: STEP_W];
   end

   // Row and column weights, stages one and two.
   bzp_weight u_row_wgt (
      .clock    (clock),
      .step     (row_step),
      .lvl_eff  (lvl_eff),
      .recip    (recip),
      .stage_en (wt_en),
      .wgt      (wr)
   );

   bzp_weight u_col_wgt (
      .clock    (clock),
      .step     (col_step),
      .lvl_eff  (lvl_eff),
      .recip    (recip),
      .stage_en (wt_en),
      .wgt      (wc)
   );

   // Row blend products; each fits in signed 64 bits.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_full[r][c] = $signed({1'b0, wr[r]}) * $signed(ctrl_s2_ff[r][c]);
         end
      end
   end

   // Column sums; the weights are convex so the sum stays in 64 bits.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_in[c] = prod_s3_ff[0][c] + prod_s3_ff[1][c] + prod_s3_ff[2][c];
      end
   end

   // Column weighting split into upper and lower 32-bit partial products.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pph_full[c] = $signed(col_s4_ff[c][63:32]) * $signed({1'b0, wc_s4_ff[c]});
         ppl_full[c] = col_s4_ff[c][31:0] * wc_s4_ff[c];
      end
   end

   // Recombine the partial products into exact terms at scale 2^64.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         term_in[c] = $signed({pph_s5_ff[c][63], pph_s5_ff[c], 32'd0})
                    + $signed({33'd0, ppl_s5_ff[c]});
      end
   end

   // Final sum with the rounding half added.
   assign acc_in = term_s6_ff[0] + term_s6_ff[1] + term_s6_ff[2] + RND_HALF;

   // Round by truncation of the low 64 bits, then saturate to 32 bits.
   always_comb begin
      rnd_val = acc_s7_ff[ACC_W-1:64];
      sat_in  = rnd_val[32] ^ rnd_val[31];
      if (sat_in) begin
         point_in = rnd_val[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         point_in = rnd_val[31:0];
      end
   end

   // Payload registers of stages one to eight.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         ctrl_s1_ff <= ctrl_in;
      end
      if (adv[2]) begin
         ctrl_s2_ff <= ctrl_s1_ff;
      end
      if (adv[3]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_s3_ff[r][c] <= prod_full[r][c][63:0];
            end
         end
         wc_s3_ff <= wc;
      end
      if (adv[4]) begin
         col_s4_ff <= col_in;
         wc_s4_ff  <= wc_s3_ff;
      end
      if (adv[5]) begin
         for (int c = 0; c < 3; c++) begin
            pph_s5_ff[c] <= pph_full[c][63:0];
            ppl_s5_ff[c] <= ppl_full[c][63:0];
         end
      end
      if (adv[6]) begin
         term_s6_ff <= term_in;
      end
      if (adv[7]) begin
         acc_s7_ff <= acc_in;
      end
      if (adv[8]) begin
         point_s8_ff <= point_in;
         sat_s8_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = vld_ff[NST];
   assign rsp_tdata  = point_s8_ff;
   assign rsp_tuser  = sat_s8_ff;

   // The row and column weights of a valid item always sum to one.
   a_row_wgt_sum: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (34'(wr[0]) + 34'(wr[1]) + 34'(wr[2]) == 34'h1_0000_0000))
      else $error("row weights do not sum to one");

   a_col_wgt_sum: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (34'(wc[0]) + 34'(wc[1]) + 34'(wc[2]) == 34'h1_0000_0000))
      else $error("column weights do not sum to one");

   // A saturated result carries one of the two clip values.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("saturated result is not a clip value");

   // A full stage behind a stalled output keeps its item.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST] && !rsp_tready && vld_ff[NST-1]) |=> vld_ff[NST-1])
      else $error("item lost behind a stalled output");

   // The effective level is never zero.
   a_lvl_nonzero: assert property (@(posedge clock) disable iff (reset)
      lvl_eff != '0)
      else $error("effective level is zero");

endmodule

`default_nettype wire

[test/bezier_patch_point_eval_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bezier patch point evaluator testbench
// Drives control-value transactions into the evaluator with a range of tessellation
// levels and handshake idling patterns. Each result is compared against an
// exact, wide-integer evaluation of the biquadratic blend computed when the
// request transaction is accepted.
// ----------------------------------------------------------------------------

module bezier_patch_point_eval_core_tb;

   localparam int MAX_LEVEL    = 16;
   localparam int PIPE_LATENCY = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SEG_POINTS   = 125;

   // One request transaction: control values indexed row * 3 + column.
   typedef struct {
      logic [8:0][31:0] ctrl;
      logic [4:0]       row_step;
      logic [4:0]       col_step;
   } patch_req_type;

   typedef struct {
      logic [31:0] point_value;
      logic        saturated;
   } point_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [bzp_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [bzp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic                            csr_wr_en   = 1'b0;
   logic [bzp_pkg::LVL_W-1:0]       csr_wr_data = '0;

   // Level as the block should currently hold it.
   logic [4:0]       level_model = bzp_pkg::LEVEL_RESET;
   point_result_type pending_points [$];
   point_result_type expected_point;
   int               fail_count  = 0;
   int               req_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               cycle_count = 0;

   always #6 clock = ~clock;

   bezier_patch_point_eval_core #(
      .MAX_LEVEL(MAX_LEVEL)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // A level of zero acts as one, and levels above the maximum are capped.
   function automatic longint effective_level(input logic [4:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_LEVEL) return MAX_LEVEL;
      return longint'(raw);
   endfunction

   // Quadratic Bernstein weights at scale 2^32 for a grid step.
   function automatic void bernstein_weights(input logic [4:0] step, input longint lvl,
                                             output longint wgt [3]);
      longint clamped;
      longint t_q16;
      longint s_q16;
      clamped = (longint'(step) > lvl) ? lvl : longint'(step);
      t_q16   = ((clamped << 16) + (lvl >> 1)) / lvl;
      s_q16   = 65536 - t_q16;
      wgt[0]  = s_q16 * s_q16;
      wgt[1]  = 2 * s_q16 * t_q16;
      wgt[2]  = t_q16 * t_q16;
   endfunction

   // Exact blend at scale 2^64, rounded half up and clipped to 32 bits.
   function automatic point_result_type eval_patch_point(input patch_req_type p,
                                                         input logic [4:0] lvl_raw);
      longint              lvl;
      longint              row_w [3];
      longint              col_w [3];
      logic signed [127:0] term;
      logic signed [127:0] col_sum;
      logic signed [127:0] acc;
      logic signed [127:0] rounded;
      point_result_type    res;
      lvl = effective_level(lvl_raw);
      bernstein_weights(p.row_step, lvl, row_w);
      bernstein_weights(p.col_step, lvl, col_w);
      acc = '0;
      for (int c = 0; c < 3; c++) begin
         col_sum = '0;
         for (int r = 0; r < 3; r++) begin
            term    = $signed(p.ctrl[r*3+c]);
            col_sum = col_sum + term * row_w[r];
         end
         acc = acc + col_sum * col_w[c];
      end
      acc     = acc + (128'sd1 <<< 63);
      rounded = acc >>> 64;
      res.saturated = 1'b0;
      if (rounded > 128'sd2147483647) begin
         res.point_value = 32'h7FFF_FFFF;
         res.saturated   = 1'b1;
      end else if (rounded < -128'sd2147483648) begin
         res.point_value = 32'h8000_0000;
         res.saturated   = 1'b1;
      end else begin
         res.point_value = rounded[31:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH: %s", msg);
   endfunction

   // Sends one request transaction, idling the sender at random first.
   // Valid stays high afterward so back-to-back transactions need no gap.
   task automatic send_patch_point(input patch_req_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {6'b0, p.col_step, p.row_step, p.ctrl};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_points.insert(pending_points.size(), eval_patch_point(p, level_model));
   endtask

   // Holds off the sender until every expected result has come back.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // Writes the level register; only called while the block is idle.
   task automatic write_level(input logic [4:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      level_model = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_ctrl_value(input int unsigned kind);
      case (kind)
         0: return $urandom;
         1: return 32'($urandom_range(32'h1F_FFFF)) - 32'h10_0000;
         default: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Random grid point: mostly inside the level, sometimes beyond it.
   function automatic patch_req_type random_patch_point();
      patch_req_type p;
      int unsigned   kind;
      longint        lvl;
      kind = $urandom_range(3);
      lvl  = effective_level(level_model);
      for (int k = 0; k < 9; k++) p.ctrl[k] = random_ctrl_value(kind);
      // A flat patch must give back its control value.
      if (kind == 3) for (int k = 1; k < 9; k++) p.ctrl[k] = p.ctrl[0];
      if ($urandom_range(9) < 8) begin
         p.row_step = 5'($urandom_range(int'(lvl)));
         p.col_step = 5'($urandom_range(int'(lvl)));
      end else begin
         p.row_step = 5'($urandom_range(31));
         p.col_step = 5'($urandom_range(31));
      end
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Corners, field extremes, rounding ties and step clamping at the
   // reset level of eight.
   task automatic test_reset_level_corners();
      patch_req_type p;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;

      p.ctrl = '0; p.row_step = 5'd0; p.col_step = 5'd0; send_patch_point(p);
      p.ctrl = {9{32'h7FFF_FFFF}}; p.row_step = 5'd8; p.col_step = 5'd8; send_patch_point(p);
      p.ctrl = {9{32'h8000_0000}}; p.row_step = 5'd0; p.col_step = 5'd8; send_patch_point(p);

      // Checkerboard of the two extremes at the patch center.
      for (int k = 0; k < 9; k++) p.ctrl[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.row_step = 5'd4; p.col_step = 5'd4; send_patch_point(p);

      // The center weights a quarter of the middle value: +0.5 and -0.5 ties.
      p.ctrl = '0; p.ctrl[4] = 32'd2;          send_patch_point(p);
      p.ctrl[4] = 32'hFFFF_FFFE;               send_patch_point(p);

      // Distinct values pick out one corner exactly.
      for (int k = 0; k < 9; k++) p.ctrl[k] = 32'h0001_0000 * (k + 1) + k;
      p.row_step = 5'd8;  p.col_step = 5'd0;  send_patch_point(p);
      // Steps past the level clamp to the far corner.
      p.row_step = 5'd31; p.col_step = 5'd9;  send_patch_point(p);

      for (int k = 0; k < 9; k++) p.ctrl[k] = $urandom;
      p.row_step = 5'd31; p.col_step = 5'd31; send_patch_point(p);
      drain_pipeline();
   endtask

   // Zero, the smallest and largest legal levels and levels above the cap.
   task automatic test_level_extremes();
      logic [4:0] levels [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
      patch_req_type p;
      foreach (levels[i]) begin
         write_level(levels[i]);
         for (int n = 0; n < 3; n++) begin
            for (int k = 0; k < 9; k++) p.ctrl[k] = $urandom;
            p.row_step = (n == 0) ? 5'd1  : 5'($urandom_range(31));
            p.col_step = (n == 0) ? 5'd31 : 5'($urandom_range(31));
            send_patch_point(p);
         end
         drain_pipeline();
      end
   endtask

   // Random stream in segments, each under a fresh random level.
   task automatic test_random_stream(input int req_idle, input int rsp_stall);
      req_idle_pct  = req_idle;
      rsp_stall_pct = rsp_stall;
      for (int seg = 0; seg < 3; seg++) begin
         write_level(5'($urandom_range(31)));
         for (int n = 0; n < SEG_POINTS; n++) send_patch_point(random_patch_point());
         drain_pipeline();
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver, result checking and run limit
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            report_failure($sformatf("unexpected result value=%h sat=%b",
                                     rsp_tdata, rsp_tuser));
         end else begin
            expected_point = pending_points.pop_front();
            if (rsp_tdata !== expected_point.point_value ||
                rsp_tuser !== expected_point.saturated) begin
               report_failure($sformatf("expected value=%h sat=%b, got value=%h sat=%b",
                                        expected_point.point_value,
                                        expected_point.saturated, rsp_tdata, rsp_tuser));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_level_corners();
      test_level_extremes();
      test_random_stream(0, 0);
      test_random_stream(63, 0);
      test_random_stream(0, 63);
      test_random_stream(7, 7);

      drain_pipeline();
      if (pending_points.size() != 0) report_failure("results still outstanding");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bzp_pkg.sv
hw/rtl/bzp_weight.sv
hw/rtl/bezier_patch_point_eval_core.sv
test/bezier_patch_point_eval_core_tb.sv
